[rtl/clf_pkg.sv]
// Shared types and constants for the CRLF line framer.
`default_nettype none

package clf_pkg;

    localparam int unsigned CNT_W     = 21;
    localparam int unsigned BYTE_W    = 8;
    localparam logic [CNT_W-1:0] LIMIT_CAP = 21'd1048576;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EOL      = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    // One queue entry holds every result of one input byte; pre_cr marks a
    // released CR that goes out ahead of the main result.
    typedef struct packed {
        logic              pre_cr;
        logic [BYTE_W-1:0] data;
        kind_t             kind;
    } qent_t;

endpackage

`default_nettype wire

[rtl/clf_in_if.sv]
// Byte input channel: valid/ready with byte and chunk-end flag.
`default_nettype none

interface clf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

`default_nettype wire

[rtl/clf_out_if.sv]
// Result output channel: valid/ready with byte, kind and last flag.
`default_nettype none

interface clf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_item;

    modport source (output valid, output out_byte, output out_kind,
                    output last_of_item, input ready);
    modport sink   (input valid, input out_byte, input out_kind,
                    input last_of_item, output ready);
endinterface

`default_nettype wire

[rtl/clf_front.sv]
// Front end: limit register, line state and per-byte classification.
`default_nettype none

module clf_front
    import clf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [CNT_W-1:0] wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             chunk_end,
    input  wire logic             q_full,
    output logic                  push,
    output qent_t                 push_ent
);

    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic             cr_held_reg, cr_held_next;
    logic             discarding_reg, discarding_next;

    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] cnt_adj;
    logic             is_lf, is_cr, accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_CAP;
            line_count_reg <= '0;
            cr_held_reg    <= 1'b0;
            discarding_reg <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            line_count_reg <= line_count_next;
            cr_held_reg    <= cr_held_next;
            discarding_reg <= discarding_next;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_lf    = (in_byte == BYTE_LF);
    assign is_cr    = (in_byte == BYTE_CR);
    assign lim      = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
    // a held CR before LF is dropped, so it does not count toward the line
    assign cnt_adj  = (cr_held_reg && line_count_reg != '0) ?
                      line_count_reg - CNT_W'(1) : line_count_reg;

    always_comb
    begin
        limit_next      = wr_en ? wr_data : limit_reg;
        line_count_next = line_count_reg;
        cr_held_next    = cr_held_reg;
        discarding_next = discarding_reg;
        push            = 1'b0;
        push_ent.pre_cr = 1'b0;
        push_ent.data   = '0;
        push_ent.kind   = KIND_EOL;

        if (accept)
        begin
            if (discarding_reg)
            begin
                if (chunk_end)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (is_lf)
            begin
                push         = 1'b1;
                cr_held_next = 1'b0;
                line_count_next = '0;
                if (cnt_adj > lim)
                begin
                    push_ent.kind   = KIND_OVERFLOW;
                    discarding_next = !chunk_end;
                end
                else
                begin
                    push_ent.kind = KIND_EOL;
                end
            end
            else if ((line_count_reg == lim && !is_cr) || line_count_reg > lim)
            begin
                push            = 1'b1;
                push_ent.kind   = KIND_OVERFLOW;
                line_count_next = '0;
                cr_held_next    = 1'b0;
                discarding_next = !chunk_end;
            end
            else
            begin
                line_count_next = line_count_reg + CNT_W'(1);
                if (is_cr)
                begin
                    // release an earlier CR, hold this one
                    push            = cr_held_reg;
                    push_ent.data   = BYTE_CR;
                    push_ent.kind   = KIND_PAYLOAD;
                    cr_held_next    = 1'b1;
                end
                else
                begin
                    push            = 1'b1;
                    push_ent.pre_cr = cr_held_reg;
                    push_ent.data   = in_byte;
                    push_ent.kind   = KIND_PAYLOAD;
                    cr_held_next    = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/clf_queue.sv]
// Small FIFO of per-byte result entries between front and back.
`default_nettype none

module clf_queue
    import clf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_ent,
    input  wire logic  pop,
    output logic       full,
    output logic       not_empty,
    output qent_t      head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    qent_t          entries_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

`default_nettype wire

[rtl/clf_back.sv]
// Back end: expands queue entries into results and drives the output register.
`default_nettype none

module clf_back
    import clf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  not_empty,
    input  wire qent_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       last_of_item
);

    logic       out_valid_reg, out_valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] out_byte_reg, out_byte_next;
    kind_t      out_kind_reg, out_kind_next;
    logic       out_last_reg, out_last_next;
    logic       load;

    assign load = not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head.pre_cr && !phase_reg)
            begin
                // released CR first, entry stays at the head
                out_byte_next = BYTE_CR;
                out_kind_next = KIND_PAYLOAD;
                out_last_next = 1'b0;
                phase_next    = 1'b1;
            end
            else
            begin
                out_byte_next = head.data;
                out_kind_next = head.kind;
                out_last_next = 1'b1;
                phase_next    = 1'b0;
                pop           = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_kind     = out_kind_reg;
    assign last_of_item = out_last_reg;

endmodule

`default_nettype wire

[rtl/crlf_line_framer_with_limit_top.sv]
// Top level of the CRLF line framer with line-length limit.
//
//  channel   dir   handshake      payload
//  bytes     sink  valid/ready    in_byte[7:0], chunk_end
//  results   src   valid/ready    out_byte[7:0], out_kind[1:0], last_of_item
//  config    sink  wr_en          wr_data[20:0] (max_line_bytes)
//
// One byte is accepted per cycle while the result queue has room; each queued
// entry yields one result, or two when a held CR is released ahead of a byte.
// A byte's entry is queued first, then loaded into the output register from the head.
// Reset clears line state and sets the limit to 1048576; no clearing pass.
// A stalled result side fills the queue, then bytes.ready drops.
`default_nettype none

module crlf_line_framer_with_limit_top
    import clf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [CNT_W-1:0] wr_data,
    clf_in_if.sink                bytes,
    clf_out_if.source             results
);

    logic  q_full, q_not_empty, q_push, q_pop;
    qent_t q_push_ent, q_head;

    clf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .in_valid  (bytes.valid),
        .in_ready  (bytes.ready),
        .in_byte   (bytes.in_byte),
        .chunk_end (bytes.chunk_end),
        .q_full    (q_full),
        .push      (q_push),
        .push_ent  (q_push_ent)
    );

    clf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ent  (q_push_ent),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    clf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (q_not_empty),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_byte     (results.out_byte),
        .out_kind     (results.out_kind),
        .last_of_item (results.last_of_item)
    );

endmodule

`default_nettype wire
